>>> src/mcks_pkg.sv
// ----------------------------------------------------------------------------
// mcks_pkg: shared types and constants
// Step counts, sequencer states and control structs for the keystream block.
// ----------------------------------------------------------------------------
package mcks_pkg;

    localparam int unsigned KEY_W        = 64;
    localparam int unsigned FRAME_W      = 22;
    localparam int unsigned CHUNK_W      = 57;
    localparam int unsigned MIX_STEPS    = 100;
    localparam int unsigned CNT_W        = 7;   // holds up to MIX_STEPS - 1
    localparam int unsigned LFSR1_W      = 19;
    localparam int unsigned LFSR2_W      = 22;
    localparam int unsigned LFSR3_W      = 23;
    localparam int unsigned CHUNK_CNT_W  = 2;   // four chunks per frame

    localparam logic [CNT_W-1:0] KEY_LAST   = CNT_W'(KEY_W - 1);
    localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_W - 1);
    localparam logic [CNT_W-1:0] MIX_LAST   = CNT_W'(MIX_STEPS - 1);
    localparam logic [CNT_W-1:0] CHUNK_LAST = CNT_W'(CHUNK_W - 1);

    localparam logic [CHUNK_CNT_W-1:0] FINAL_CHUNK = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_FRAME,
        ST_MIX,
        ST_GEN,
        ST_HAND
    } t_state;

    // LFSR step control
    typedef struct packed {
        logic clr;      // clear all three registers
        logic clk_all;  // regular clock, XOR din into cell 0
        logic maj;      // majority clock
        logic din;
    } t_lfsr_ctl;

    // output stage control
    typedef struct packed {
        logic shift;    // take one keystream bit
        logic push;     // move finished chunk into the output register
        logic which_burst;
        logic chunk_index;
        logic last;
    } t_out_ctl;

endpackage

>>> src/mcks_frame_if.sv
// ----------------------------------------------------------------------------
// mcks_frame_if: frame number channel
// valid/ready channel carrying one 22-bit frame number per transfer.
// ----------------------------------------------------------------------------
interface mcks_frame_if;
    logic                           valid;
    logic                           ready;
    logic [mcks_pkg::FRAME_W-1:0]   frame_number;

    modport source (output valid, output frame_number, input ready);
    modport sink   (input valid, input frame_number, output ready);
endinterface

>>> src/mcks_chunk_if.sv
// ----------------------------------------------------------------------------
// mcks_chunk_if: keystream chunk channel
// valid/ready channel carrying one 57-bit keystream chunk per transfer.
// ----------------------------------------------------------------------------
interface mcks_chunk_if;
    logic                           valid;
    logic                           ready;
    logic                           which_burst;
    logic                           chunk_index;
    logic [mcks_pkg::CHUNK_W-1:0]   keystream_bits;
    logic                           last;

    modport source (output valid, output which_burst, output chunk_index,
                    output keystream_bits, output last, input ready);
    modport sink   (input valid, input which_burst, input chunk_index,
                    input keystream_bits, input last, output ready);
endinterface

>>> src/mcks_lfsr.sv
// ----------------------------------------------------------------------------
// mcks_lfsr: three-register LFSR core
// Regular or majority clocking, one step per enabled cycle; keystream bit after step.
// ----------------------------------------------------------------------------
module mcks_lfsr (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcks_pkg::t_lfsr_ctl   i_ctl,
    output logic                  o_ks_bit
);

    logic [mcks_pkg::LFSR1_W-1:0] r_one,   n_one,   sh_one;
    logic [mcks_pkg::LFSR2_W-1:0] r_two,   n_two,   sh_two;
    logic [mcks_pkg::LFSR3_W-1:0] r_three, n_three, sh_three;
    logic x, y, z, m;

    always_comb begin
        sh_one   = {r_one[17:0],   r_one[18] ^ r_one[17] ^ r_one[16] ^ r_one[13]};
        sh_two   = {r_two[20:0],   r_two[21] ^ r_two[20]};
        sh_three = {r_three[21:0], r_three[22] ^ r_three[21] ^ r_three[20] ^ r_three[7]};

        x = r_one[8];
        y = r_two[10];
        z = r_three[10];
        m = (x & y) | (x & z) | (y & z);

        n_one   = r_one;
        n_two   = r_two;
        n_three = r_three;
        if (i_ctl.clr) begin
            n_one   = '0;
            n_two   = '0;
            n_three = '0;
        end else if (i_ctl.clk_all) begin
            n_one   = sh_one   ^ {{(mcks_pkg::LFSR1_W-1){1'b0}}, i_ctl.din};
            n_two   = sh_two   ^ {{(mcks_pkg::LFSR2_W-1){1'b0}}, i_ctl.din};
            n_three = sh_three ^ {{(mcks_pkg::LFSR3_W-1){1'b0}}, i_ctl.din};
        end else if (i_ctl.maj) begin
            if (x == m) n_one   = sh_one;
            if (y == m) n_two   = sh_two;
            if (z == m) n_three = sh_three;
        end
    end

    // output bit is taken after the clock
    assign o_ks_bit = n_one[18] ^ n_two[21] ^ n_three[22];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one   <= '0;
            r_two   <= '0;
            r_three <= '0;
        end else begin
            r_one   <= n_one;
            r_two   <= n_two;
            r_three <= n_three;
        end
    end

endmodule

>>> src/mcks_outbuf.sv
// ----------------------------------------------------------------------------
// mcks_outbuf: chunk collector and output register
// Shifts keystream bits into a 57-bit word, then holds it for transfer.
// ----------------------------------------------------------------------------
module mcks_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcks_pkg::t_out_ctl    i_ctl,
    input  logic                  i_ks_bit,
    output logic                  o_can_push,
    mcks_chunk_if.source          o_chunk
);

    logic [mcks_pkg::CHUNK_W-1:0] r_collect;
    logic [mcks_pkg::CHUNK_W-1:0] r_bits;
    logic                         r_which, r_idx, r_last;
    logic                         r_valid;

    assign o_can_push = !r_valid || o_chunk.ready;

    assign o_chunk.valid          = r_valid;
    assign o_chunk.which_burst    = r_which;
    assign o_chunk.chunk_index    = r_idx;
    assign o_chunk.keystream_bits = r_bits;
    assign o_chunk.last           = r_last;

    // earliest bit ends up at bit 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_collect <= {i_ks_bit, r_collect[mcks_pkg::CHUNK_W-1:1]};
        end
        if (i_ctl.push) begin
            r_bits  <= r_collect;
            r_which <= i_ctl.which_burst;
            r_idx   <= i_ctl.chunk_index;
            r_last  <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.push) begin
            r_valid <= 1'b1;
        end else if (o_chunk.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

>>> src/majority_clocked_lfsr_keystream.sv
// ----------------------------------------------------------------------------
// majority_clocked_lfsr_keystream: majority-clocked LFSR keystream generator
// Expands a 64-bit session key and a 22-bit frame number into two 114-bit
// keystream bursts, delivered as four 57-bit chunks.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg_we/i_cfg_wdata write the 64-bit session key; write it only while
//   the block is idle (no frame in flight).
//   i_frame takes one frame number per transfer; ready is high only when the
//   sequencer is idle.
//   o_chunk returns four transfers per frame: burst 0 chunk 0, burst 0
//   chunk 1, burst 1 chunk 0, burst 1 chunk 1 (last = 1).
// Steps (one LFSR step per cycle, none in the hand-off state; the step
//   counter sets the pace): 64 key steps + 22 frame steps + 100 mixing
//   steps, then per chunk 57 output steps and a hand-off of the chunk to
//   the output register.
// Stall: a finished chunk waits in the collector until the output register
//   is free, so a held-off receiver delays the sequencer but loses nothing.
// Reset: clears the key, the LFSRs, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module majority_clocked_lfsr_keystream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mcks_pkg::KEY_W-1:0]    i_cfg_wdata,
    mcks_frame_if.sink                    i_frame,
    mcks_chunk_if.source                  o_chunk
);

    mcks_pkg::t_state                     r_state, n_state;
    logic [mcks_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic [mcks_pkg::CHUNK_CNT_W-1:0]     r_chunk, n_chunk;
    logic [mcks_pkg::KEY_W-1:0]           r_secret_key;
    logic [mcks_pkg::KEY_W-1:0]           r_key_sr;
    logic [mcks_pkg::FRAME_W-1:0]         r_frame_sr;

    mcks_pkg::t_lfsr_ctl                  lfsr_ctl;
    mcks_pkg::t_out_ctl                   out_ctl;
    logic                                 ks_bit;
    logic                                 can_push;
    logic                                 in_xfer;

    assign in_xfer = i_frame.valid && i_frame.ready;

    // session key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret_key <= '0;
        end else if (i_cfg_we) begin
            r_secret_key <= i_cfg_wdata;
        end
    end

    // key and frame bits leave LSB first, one per step
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key_sr   <= r_secret_key;
            r_frame_sr <= i_frame.frame_number;
        end else begin
            if (r_state == mcks_pkg::ST_KEY) begin
                r_key_sr <= {1'b0, r_key_sr[mcks_pkg::KEY_W-1:1]};
            end
            if (r_state == mcks_pkg::ST_FRAME) begin
                r_frame_sr <= {1'b0, r_frame_sr[mcks_pkg::FRAME_W-1:1]};
            end
        end
    end

    // next state, step counter, chunk counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_chunk = r_chunk;
        case (r_state)
            mcks_pkg::ST_IDLE: begin
                if (i_frame.valid) begin
                    n_state = mcks_pkg::ST_KEY;
                    n_cnt   = '0;
                    n_chunk = '0;
                end
            end
            mcks_pkg::ST_KEY: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mcks_pkg::KEY_LAST) begin
                    n_state = mcks_pkg::ST_FRAME;
                    n_cnt   = '0;
                end
            end
            mcks_pkg::ST_FRAME: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mcks_pkg::FRAME_LAST) begin
                    n_state = mcks_pkg::ST_MIX;
                    n_cnt   = '0;
                end
            end
            mcks_pkg::ST_MIX: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mcks_pkg::MIX_LAST) begin
                    n_state = mcks_pkg::ST_GEN;
                    n_cnt   = '0;
                end
            end
            mcks_pkg::ST_GEN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mcks_pkg::CHUNK_LAST) begin
                    n_state = mcks_pkg::ST_HAND;
                    n_cnt   = '0;
                end
            end
            mcks_pkg::ST_HAND: begin
                if (can_push) begin
                    n_chunk = r_chunk + 1'b1;
                    n_state = (r_chunk == mcks_pkg::FINAL_CHUNK) ?
                              mcks_pkg::ST_IDLE : mcks_pkg::ST_GEN;
                end
            end
            default: begin
                n_state = mcks_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        i_frame.ready       = 1'b0;
        lfsr_ctl            = '0;
        out_ctl             = '0;
        out_ctl.which_burst = r_chunk[1];
        out_ctl.chunk_index = r_chunk[0];
        out_ctl.last        = (r_chunk == mcks_pkg::FINAL_CHUNK);
        case (r_state)
            mcks_pkg::ST_IDLE: begin
                i_frame.ready = 1'b1;
                lfsr_ctl.clr  = i_frame.valid;
            end
            mcks_pkg::ST_KEY: begin
                lfsr_ctl.clk_all = 1'b1;
                lfsr_ctl.din     = r_key_sr[0];
            end
            mcks_pkg::ST_FRAME: begin
                lfsr_ctl.clk_all = 1'b1;
                lfsr_ctl.din     = r_frame_sr[0];
            end
            mcks_pkg::ST_MIX: begin
                lfsr_ctl.maj = 1'b1;
            end
            mcks_pkg::ST_GEN: begin
                lfsr_ctl.maj  = 1'b1;
                out_ctl.shift = 1'b1;
            end
            mcks_pkg::ST_HAND: begin
                out_ctl.push = can_push;
            end
            default: begin
                lfsr_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcks_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_chunk <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chunk <= n_chunk;
        end
    end

    mcks_lfsr u_lfsr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lfsr_ctl),
        .o_ks_bit (ks_bit)
    );

    mcks_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (out_ctl),
        .i_ks_bit   (ks_bit),
        .o_can_push (can_push),
        .o_chunk    (o_chunk)
    );

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: majority_clocked_lfsr_keystream
// Drives frame numbers under several session keys and checks every keystream
// chunk, field by field, against a cycle-free model of the three LFSRs.
// Random idling on both channels, a long receiver hold-off and sender pauses.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned KEY_W     = mcks_pkg::KEY_W;
    localparam int unsigned FRAME_W   = mcks_pkg::FRAME_W;
    localparam int unsigned CHUNK_W   = mcks_pkg::CHUNK_W;
    localparam int unsigned MIX_STEPS = mcks_pkg::MIX_STEPS;
    localparam int unsigned LFSR1_W   = mcks_pkg::LFSR1_W;
    localparam int unsigned LFSR2_W   = mcks_pkg::LFSR2_W;
    localparam int unsigned LFSR3_W   = mcks_pkg::LFSR3_W;

    // run limits, in clock cycles
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;     // after the last chunk
    localparam int unsigned END_CYCLES    = 64;    // watch for stray chunks
    localparam int unsigned HOLD_CYCLES   = 1500;  // > three frames of work

    localparam logic [FRAME_W-1:0] FRAME_MAX  = '1;
    localparam int unsigned        RAND_PHASES = 8;
    localparam int unsigned        PHASE_ITEMS = 17;

    // one keystream chunk as seen on the output channel
    typedef struct packed {
        logic               which_burst;
        logic               chunk_index;
        logic [CHUNK_W-1:0] keystream_bits;
        logic               last;
    } t_chunk;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic               i_cfg_we;
    logic [KEY_W-1:0]   i_cfg_wdata;

    mcks_frame_if frame_ch ();
    mcks_chunk_if chunk_ch ();

    // model state: key as the block holds it, and chunks still to arrive
    logic [KEY_W-1:0] session_key_copy;
    t_chunk           expected_chunks[$];

    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned rx_hold_cycles  = 0;   // nonzero asks the receiver to hold off
    bit          tx_no_idle      = 1'b0;
    bit          rx_no_idle      = 1'b0;

    majority_clocked_lfsr_keystream i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (frame_ch),
        .o_chunk     (chunk_ch)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Keystream model
    // ------------------------------------------------------------------------
    // Regular shifts; cell 0 takes the feedback.
    function automatic logic [LFSR1_W-1:0] shift_r1(input logic [LFSR1_W-1:0] r);
        return {r[17:0], r[18] ^ r[17] ^ r[16] ^ r[13]};
    endfunction

    function automatic logic [LFSR2_W-1:0] shift_r2(input logic [LFSR2_W-1:0] r);
        return {r[20:0], r[21] ^ r[20]};
    endfunction

    function automatic logic [LFSR3_W-1:0] shift_r3(input logic [LFSR3_W-1:0] r);
        return {r[21:0], r[22] ^ r[21] ^ r[20] ^ r[7]};
    endfunction

    // Runs one whole frame and queues its four chunks.
    function automatic void predict_keystream(input logic [KEY_W-1:0]   key,
                                              input logic [FRAME_W-1:0] frame);
        logic [LFSR1_W-1:0] r1;
        logic [LFSR2_W-1:0] r2;
        logic [LFSR3_W-1:0] r3;
        logic               bit_in, x, y, z, maj;
        int                 pos, k;
        t_chunk             c;
        // registers start cleared for every frame
        r1 = '0;
        r2 = '0;
        r3 = '0;
        c  = '0;
        // key bits then frame bits, LSB first, XORed in after each clock
        for (int i = 0; i < KEY_W + FRAME_W; i++) begin
            bit_in = (i < KEY_W) ? key[i] : frame[i - KEY_W];
            r1 = shift_r1(r1);
            r2 = shift_r2(r2);
            r3 = shift_r3(r3);
            r1[0] = r1[0] ^ bit_in;
            r2[0] = r2[0] ^ bit_in;
            r3[0] = r3[0] ^ bit_in;
        end
        // majority clocking: mixing steps first, then one output bit per step
        for (int n = 0; n < MIX_STEPS + 4 * CHUNK_W; n++) begin
            x   = r1[8];
            y   = r2[10];
            z   = r3[10];
            maj = (x & y) | (x & z) | (y & z);
            if (x == maj) r1 = shift_r1(r1);
            if (y == maj) r2 = shift_r2(r2);
            if (z == maj) r3 = shift_r3(r3);
            if (n >= MIX_STEPS) begin
                pos = n - MIX_STEPS;
                c.keystream_bits[pos % CHUNK_W] = r1[18] ^ r2[21] ^ r3[22];
                if (pos % CHUNK_W == CHUNK_W - 1) begin
                    k = pos / CHUNK_W;
                    c.which_burst = k[1];
                    c.chunk_index = k[0];
                    c.last        = (k == 3);
                    expected_chunks.push_back(c);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and scoreboard: tracks key writes, predicts on every accepted
    // frame and checks every accepted chunk against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_chunk exp_c;
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else if (!i_rst_n) begin
            session_key_copy = '0;
        end else begin
            if (i_cfg_we) begin
                session_key_copy = i_cfg_wdata;
            end
            if (chunk_ch.valid && chunk_ch.ready) begin
                if (expected_chunks.size() == 0) begin
                    $error("chunk transfer with nothing expected: bits %h",
                           chunk_ch.keystream_bits);
                    mismatch_count++;
                end else begin
                    exp_c = expected_chunks.pop_front();
                    if (chunk_ch.which_burst !== exp_c.which_burst) begin
                        $error("which_burst: expected %0d, actual %0d",
                               exp_c.which_burst, chunk_ch.which_burst);
                        mismatch_count++;
                    end
                    if (chunk_ch.chunk_index !== exp_c.chunk_index) begin
                        $error("chunk_index: expected %0d, actual %0d",
                               exp_c.chunk_index, chunk_ch.chunk_index);
                        mismatch_count++;
                    end
                    if (chunk_ch.keystream_bits !== exp_c.keystream_bits) begin
                        $error("keystream_bits: expected %h, actual %h",
                               exp_c.keystream_bits, chunk_ch.keystream_bits);
                        mismatch_count++;
                    end
                    if (chunk_ch.last !== exp_c.last) begin
                        $error("last: expected %0d, actual %0d",
                               exp_c.last, chunk_ch.last);
                        mismatch_count++;
                    end
                end
            end
            if (frame_ch.valid && frame_ch.ready) begin
                predict_keystream(session_key_copy, frame_ch.frame_number);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Chunk receiver: random stall before each transfer, none while rx_no_idle
    // is set; a requested hold-off is counted out here.
    // ------------------------------------------------------------------------
    initial begin : chunk_receiver
        int unsigned gap;
        chunk_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
                chunk_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                gap = rx_no_idle ? 0 : $urandom_range(0, 4);
                if (gap != 0) begin
                    chunk_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            chunk_ch.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(chunk_ch.valid && chunk_ch.ready) && rx_hold_cycles == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offers one frame after a random gap and returns on its transfer edge.
    // valid stays high when the next frame follows with no gap.
    task automatic send_frame(input logic [FRAME_W-1:0] frame);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.frame_number <= frame;
        do @(posedge i_clk); while (!frame_ch.ready);
    endtask

    // Stops offering and waits until every queued chunk has come back.
    task automatic wait_for_chunks();
        frame_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Key writes happen only with the block idle.
    task automatic write_key(input logic [KEY_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Key left at its reset value of zero; frame 0 gives an all-zero keystream.
    task automatic test_reset_key();
        send_frame('0);
        send_frame(FRAME_MAX);
        send_frame(FRAME_W'(1));
        wait_for_chunks();
    endtask

    // Extreme keys against extreme and alternating frames.
    task automatic test_key_extremes();
        write_key('1);
        send_frame('0);
        send_frame(FRAME_MAX);
        send_frame(FRAME_W'(1) << (FRAME_W - 1));
        send_frame(FRAME_W'(22'h2AAAAA));
        wait_for_chunks();
        write_key(KEY_W'(1) << (KEY_W - 1));
        send_frame(FRAME_W'(22'h155555));
        send_frame(FRAME_W'(1));
        wait_for_chunks();
        write_key(KEY_W'(1));
        send_frame('0);
        send_frame(FRAME_MAX);
        wait_for_chunks();
    endtask

    // Registers are cleared per frame: a repeated frame repeats its keystream.
    task automatic test_frame_reuse();
        logic [FRAME_W-1:0] fa, fb;
        fa = FRAME_W'($urandom_range(0, FRAME_MAX));
        fb = FRAME_W'($urandom_range(0, FRAME_MAX));
        write_key({$urandom, $urandom});
        send_frame(fa);
        send_frame(fa);
        send_frame(fb);
        send_frame(fa);
        wait_for_chunks();
    endtask

    // Receiver holds off while frames keep coming: the block fills and
    // drops frame ready until the hold ends.
    task automatic test_receiver_hold();
        rx_hold_cycles = HOLD_CYCLES;
        repeat (3) send_frame(FRAME_W'($urandom_range(0, FRAME_MAX)));
        wait_for_chunks();
    endtask

    // Sender waits for every chunk before offering the next frame.
    task automatic test_sender_pause();
        repeat (3) begin
            send_frame(FRAME_W'($urandom_range(0, FRAME_MAX)));
            wait_for_chunks();
        end
    endtask

    // Random frames in phases, each phase under its own key; one phase runs
    // with no idling on either side.
    task automatic test_random_frames();
        logic [KEY_W-1:0] key;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: key = '1;
                1: key = '0;
                default: key = {$urandom, $urandom};
            endcase
            write_key(key);
            tx_no_idle = (p == 3);
            rx_no_idle = (p == 3);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    send_frame($urandom_range(0, 1) ? FRAME_MAX : '0);
                else
                    send_frame(FRAME_W'($urandom_range(0, FRAME_MAX)));
            end
            wait_for_chunks();
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        frame_ch.valid        = 1'b0;
        frame_ch.frame_number = '0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_key_extremes();
        test_frame_reuse();
        test_receiver_hold();
        test_sender_pause();
        test_random_frames();

        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chunks.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
